// ===== sv/cfq_pkg.sv =====
// Shared types and constants of the circular FIFO queue.
`default_nettype none

package cfq_pkg;

  // Operation requested by one input item.
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_PEEK  = 2'd3
  } kind_e;

  // Outcome of one operation.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_e;

  // Word shown at the head when the queue holds nothing (+infinity pattern).
  localparam logic [63:0] EMPTY_WORD = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] front_value;
    logic [3:0]  count;
    logic        is_empty;
    logic        is_full;
  } out_item_t;

  // Queue condition after an operation, passed from the pointer logic.
  typedef struct packed {
    status_e    status;
    logic [3:0] count;
    logic       empty;
    logic       full;
  } rsp_info_t;

endpackage

`default_nettype wire

// ===== sv/cfq_ram.sv =====
// Slot storage: one write port and one read port, registered read data.
`default_nettype none

module cfq_ram #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [63:0]   wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [63:0]   rd_data_o
);

  logic [63:0] mem [SLOTS];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; a read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cfq_ptr.sv =====
// Head and tail pointers, operation decode and queue condition.
`default_nettype none

module cfq_ptr
  import cfq_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire kind_e         kind_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [AW-1:0]      rd_addr_o,
  output rsp_info_t          info_o
);

  localparam logic [AW-1:0] LAST  = AW'(SLOTS - 1);
  localparam logic [AW:0]   NSLOT = (AW + 1)'(SLOTS);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] tail_adv, head_adv, tail_d_adv;
  logic          empty_now, full_now;
  logic          push_ok;
  status_e       status;
  logic [AW:0]   held;
  logic [AW+4:0] held_ext;

  // Advance with wrap at the last slot.
  assign tail_adv   = (tail_q == LAST) ? '0 : tail_q + 1'b1;
  assign head_adv   = (head_q == LAST) ? '0 : head_q + 1'b1;
  assign tail_d_adv = (tail_d == LAST) ? '0 : tail_d + 1'b1;
  assign empty_now  = (head_q == tail_q);
  assign full_now   = (tail_adv == head_q);

  // Pointer update for the requested operation.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    status  = STATUS_OK;
    push_ok = 1'b0;
    unique case (kind_i)
      KIND_PUSH: begin
        if (full_now) begin
          status = STATUS_PUSH_FULL;
        end else begin
          push_ok = 1'b1;
          tail_d  = tail_adv;
        end
      end
      KIND_POP: begin
        if (empty_now) begin
          status = STATUS_POP_EMPTY;
        end else begin
          head_d = head_adv;
        end
      end
      KIND_CLEAR: begin
        head_d = '0;
        tail_d = '0;
      end
      KIND_PEEK: begin
      end
    endcase
  end

  // Words held after the operation, taken modulo the slot count.
  always_comb begin
    if (tail_d >= head_d) begin
      held = {1'b0, tail_d} - {1'b0, head_d};
    end else begin
      held = {1'b0, tail_d} + NSLOT - {1'b0, head_d};
    end
    held_ext = {4'b0000, held};
  end

  assign wr_en_o      = accept_i & push_ok;
  assign wr_addr_o    = tail_q;
  assign rd_addr_o    = head_d;
  assign info_o.status = status;
  assign info_o.count  = held_ext[3:0];
  assign info_o.empty  = (head_d == tail_d);
  assign info_o.full   = (tail_d_adv == head_d);

  // Pointer registers change only when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/circular_fifo_queue_top.sv =====
// Top level of the circular FIFO queue: pointers, slot memory and result register.
`default_nettype none

// Ring-buffer queue of 64-bit words with SLOTS slots, one always kept free, so
// it holds up to SLOTS-1 words. Each input item is a push, pop, clear or peek
// and yields one result item with the status, the head word after the
// operation (+infinity pattern when empty), the count held modulo 16 and the
// empty and full flags. The pointers update and the slot memory is read at the
// new head in the accept cycle, and the registered read data reaches the result
// register in the next one, so no new item is accepted while one is in flight or
// while a stalled result is held. A push into an empty queue forwards the pushed
// word to the result. The slot memory needs no clearing after reset.
module circular_fifo_queue_top
  import cfq_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AW = $clog2(SLOTS);

  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rsp_info_t     info;
  logic [63:0]   rd_data;

  logic          busy_q;
  logic          out_valid_q;
  rsp_info_t     info_q;
  logic          fwd_q;
  logic [63:0]   fwd_data_q;
  out_item_t     out_q;
  logic [63:0]   front;

  // Accept when no item is in flight and the result register will be free.
  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  cfq_ptr #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .kind_i    (in_item_i.kind),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .info_o    (info)
  );

  cfq_ram #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_item_i.value),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // In-flight control bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_acc;
    end
  end

  // Condition of the queue and forwarded word, held while the read completes.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      info_q     <= info;
      fwd_q      <= wr_en & (wr_addr == rd_addr);
      fwd_data_q <= in_item_i.value;
    end
  end

  // Head word: empty pattern, forwarded push or memory data.
  always_comb begin
    priority if (info_q.empty) begin
      front = EMPTY_WORD;
    end else if (fwd_q) begin
      front = fwd_data_q;
    end else begin
      front = rd_data;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (busy_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_q.status      <= info_q.status;
      out_q.front_value <= front;
      out_q.count       <= info_q.count;
      out_q.is_empty    <= info_q.empty;
      out_q.is_full     <= info_q.full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/cfq_checker.sv =====
// Port-level checks of the circular FIFO queue and their binding.
`default_nettype none

module cfq_checker
  import cfq_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // An empty queue shows the empty pattern and a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |->
      out_item_o.front_value == EMPTY_WORD && out_item_o.count == 4'd0)
    else $error("empty result item with head word or count");

  // Failed operations agree with the flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_PUSH_FULL |-> out_item_o.is_full)
    else $error("push refused on a queue that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_POP_EMPTY |-> out_item_o.is_empty)
    else $error("pop refused on a queue that is not empty");

  // A clear yields an empty, successful result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_CLEAR |=> ##1
      out_valid_o && out_item_o.is_empty && out_item_o.status == STATUS_OK)
    else $error("clear did not yield an empty queue");

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
